>>> hdl/counter_priority_task_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the counter/priority task scheduler
// Immediate and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// check cons in the same cycle as ante
`define CPTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define CPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Item, result and cell command types shared by the scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

    localparam int TASK_W  = 4;
    localparam int SLICE_W = 8;
    localparam int PRIO_W  = 7;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [TASK_W-1:0]  task_index;
        logic [SLICE_W-1:0] slice_value;
        logic [PRIO_W-1:0]  priority_value;
        logic               present_value;
        logic               runnable_value;
    } item_t;

    typedef struct packed {
        logic [TASK_W-1:0]  running_task;
        logic               switched;
        logic [SLICE_W-1:0] running_slice;
        logic               refilled;
    } result_t;

    typedef struct packed {
        logic wr;
        logic dec;
        logic refill;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/cpts_cell.sv
// ----------------------------------------------------------------------------
// cpts_cell
// One task entry of the scheduler chain: holds slice, priority and flags,
// applies write, decrement and refill commands, and passes the best
// candidate seen so far on to the next cell every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_cell #(
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cpts_pkg::cell_cmd_t         cmd,
    input  wire cpts_pkg::item_t             wdata,
    input  wire logic [cpts_pkg::SLICE_W-1:0] prev_slice,
    input  wire logic [IDX_W-1:0]            prev_index,
    output logic      [cpts_pkg::SLICE_W-1:0] best_slice,
    output logic      [IDX_W-1:0]            best_index,
    output logic      [cpts_pkg::SLICE_W-1:0] slice
);
    import cpts_pkg::*;

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [PRIO_W-1:0]  prio_reg;
    logic               present_reg;
    logic               runnable_reg;
    logic [SLICE_W-1:0] best_slice_reg, best_slice_next;
    logic [IDX_W-1:0]   best_index_reg, best_index_next;
    logic               take;

    always_comb
    begin
        slice_next = slice_reg;
        priority if (cmd.wr)
        begin
            slice_next = wdata.slice_value;
        end
        else if (cmd.dec)
        begin
            if (slice_reg != '0)
            begin
                slice_next = slice_reg - SLICE_W'(1);
            end
        end
        else if (cmd.refill && present_reg)
        begin
            slice_next = {1'b0, slice_reg[SLICE_W-1:1]}
                       + {{(SLICE_W-PRIO_W){1'b0}}, prio_reg};
        end
        else
        begin
            slice_next = slice_reg;
        end
    end

    always_comb
    begin
        take = present_reg && runnable_reg && (slice_reg != '0)
            && (slice_reg >= prev_slice);
        best_slice_next = take ? slice_reg : prev_slice;
        best_index_next = take ? MY_INDEX  : prev_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg      <= '0;
            prio_reg       <= '0;
            present_reg    <= 1'b0;
            runnable_reg   <= 1'b0;
            best_slice_reg <= '0;
            best_index_reg <= '0;
        end
        else
        begin
            slice_reg      <= slice_next;
            best_slice_reg <= best_slice_next;
            best_index_reg <= best_index_next;
            if (cmd.wr)
            begin
                prio_reg     <= wdata.priority_value;
                present_reg  <= wdata.present_value;
                runnable_reg <= wdata.runnable_value;
            end
        end
    end

    assign best_slice = best_slice_reg;
    assign best_index = best_index_reg;
    assign slice      = slice_reg;

endmodule

`default_nettype wire

>>> hdl/counter_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Counter/priority task scheduler built as a chain of task cells with a
// small sequencer for tick, write, scan and refill.
//
// Channel   Ports                  Handshake
// item in   start, busy, item      taken when start && !busy
// result    done, result           one-cycle strobe, no back-pressure
//
// Write item: after accept, EXEC then REPORT, then done.
// Tick item: each scan waits for the candidate to ripple through the
// cell chain, and a refill adds a second scan.
// One item at a time: busy stays high from accept until done.
// Reset clears all entries and selects the idle task at once.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_priority_task_scheduler #(
    parameter int NUM_TASKS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cpts_pkg::item_t   item,
    output logic                   done,
    output cpts_pkg::result_t      result
);
    import cpts_pkg::*;

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int CNT_W = $clog2(NUM_TASKS);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_TASKS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_SCAN,
        ST_REFILL,
        ST_REPORT
    } state_t;

    state_t             state_reg;
    item_t              item_reg;
    logic [IDX_W-1:0]   current_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               switched_reg;
    logic               refilled_reg;
    logic               done_reg;
    result_t            result_reg;

    logic [SLICE_W-1:0] slice_arr [NUM_TASKS];
    logic [SLICE_W-1:0] bs_arr    [NUM_TASKS];
    logic [IDX_W-1:0]   bi_arr    [NUM_TASKS];
    cell_cmd_t          cmd_arr   [NUM_TASKS];
    logic [SLICE_W-1:0] cur_slice;
    logic               is_write;

    assign is_write  = (item_reg.func == FUNC_WRITE);
    assign cur_slice = slice_arr[current_reg];

    assign slice_arr[0] = '0;
    assign bs_arr[0]    = '0;
    assign bi_arr[0]    = '0;
    assign cmd_arr[0]   = '0;

    for (genvar i = 1; i < NUM_TASKS; i++)
    begin : g_cell
        always_comb
        begin
            cmd_arr[i].wr     = (state_reg == ST_EXEC) && is_write
                             && (int'(item_reg.task_index) == i);
            cmd_arr[i].dec    = (state_reg == ST_EXEC) && !is_write
                             && (current_reg == IDX_W'(i));
            cmd_arr[i].refill = (state_reg == ST_REFILL);
        end

        cpts_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd_arr[i]),
            .wdata      (item_reg),
            .prev_slice (bs_arr[i-1]),
            .prev_index (bi_arr[i-1]),
            .best_slice (bs_arr[i]),
            .best_index (bi_arr[i]),
            .slice      (slice_arr[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            item_reg     <= '0;
            current_reg  <= '0;
            cnt_reg      <= '0;
            switched_reg <= 1'b0;
            refilled_reg <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        item_reg     <= item;
                        switched_reg <= 1'b0;
                        refilled_reg <= 1'b0;
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    cnt_reg <= '0;
                    priority if (is_write)
                    begin
                        state_reg <= ST_REPORT;
                    end
                    else if (current_reg == '0)
                    begin
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= (cur_slice == '0) ? ST_SCAN : ST_REPORT;
                end
                ST_SCAN:
                begin
                    if (cnt_reg != SCAN_LAST)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else if ((bi_arr[NUM_TASKS-1] == '0) && !refilled_reg)
                    begin
                        state_reg <= ST_REFILL;
                    end
                    else
                    begin
                        switched_reg <= (bi_arr[NUM_TASKS-1] != current_reg);
                        current_reg  <= bi_arr[NUM_TASKS-1];
                        state_reg    <= ST_REPORT;
                    end
                end
                ST_REFILL:
                begin
                    refilled_reg <= 1'b1;
                    cnt_reg      <= '0;
                    state_reg    <= ST_SCAN;
                end
                ST_REPORT:
                begin
                    result_reg.running_task  <= TASK_W'(current_reg);
                    result_reg.switched      <= switched_reg;
                    result_reg.running_slice <= cur_slice;
                    result_reg.refilled      <= refilled_reg;
                    done_reg                 <= 1'b1;
                    state_reg                <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`include "counter_priority_task_scheduler_assert.svh"

    `CPTS_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
    `CPTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but not busy")
    `CPTS_ASSERT_IMP(a_write_quiet, done && is_write,
        !result.switched && !result.refilled, "write item reported switch or refill")
    `CPTS_ASSERT_IMP(a_idle_slice, done && (result.running_task == '0),
        result.running_slice == '0, "idle task reported a nonzero slice")

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: counter/priority task scheduler testbench
// Drives write and tick items through the start/busy handshake with random
// gaps, tracks the task table and the running task in a local copy, and
// checks every done strobe field by field against the predicted outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpts_pkg::*;

    localparam int NTASK       = 16;
    localparam int TAIL_CYCLES = 2 * NTASK + 10;
    localparam int RANDOM_ITEMS = 2000;

    class sched_tracker;
        logic [SLICE_W-1:0] slice_of [NTASK];
        logic [PRIO_W-1:0]  prio_of [NTASK];
        bit                 present_of [NTASK];
        bit                 ready_of [NTASK];
        logic [TASK_W-1:0]  cur_task;
        result_t            expected_runs[$];
        int                 errors;
        int                 n_switch;
        int                 n_refill;

        function new();
            foreach (slice_of[i])
            begin
                slice_of[i]   = '0;
                prio_of[i]    = '0;
                present_of[i] = 1'b0;
                ready_of[i]   = 1'b0;
            end
            cur_task = '0;
            errors   = 0;
            n_switch = 0;
            n_refill = 0;
        endfunction

        function logic [TASK_W-1:0] best_candidate();
            logic [TASK_W-1:0] best;
            int                best_slice;
            best       = '0;
            best_slice = 0;
            for (int i = NTASK - 1; i >= 1; i--)
            begin
                if (present_of[i] && ready_of[i] && slice_of[i] > best_slice)
                begin
                    best_slice = slice_of[i];
                    best       = TASK_W'(i);
                end
            end
            return best;
        endfunction

        function void refill_slices();
            int v;
            for (int i = 1; i < NTASK; i++)
            begin
                if (present_of[i])
                begin
                    v = (int'(slice_of[i]) >> 1) + int'(prio_of[i]);
                    slice_of[i] = (v > 255) ? 8'd255 : SLICE_W'(v);
                end
            end
        endfunction

        function void note_item(item_t it);
            result_t           r;
            logic [TASK_W-1:0] nxt;
            bit                need;
            r    = '0;
            need = 1'b0;
            if (it.func == FUNC_WRITE)
            begin
                if (it.task_index != 0 && int'(it.task_index) < NTASK)
                begin
                    slice_of[it.task_index]   = it.slice_value;
                    prio_of[it.task_index]    = it.priority_value;
                    present_of[it.task_index] = it.present_value;
                    ready_of[it.task_index]   = it.runnable_value;
                end
            end
            else
            begin
                if (cur_task == 0)
                    need = 1'b1;
                else
                begin
                    if (slice_of[cur_task] > 0)
                        slice_of[cur_task] = slice_of[cur_task] - 1'b1;
                    if (slice_of[cur_task] == 0)
                        need = 1'b1;
                end
                if (need)
                begin
                    nxt = best_candidate();
                    if (nxt == 0)
                    begin
                        refill_slices();
                        r.refilled = 1'b1;
                        n_refill++;
                        nxt = best_candidate();
                    end
                    if (nxt != cur_task)
                    begin
                        cur_task   = nxt;
                        r.switched = 1'b1;
                        n_switch++;
                    end
                end
            end
            r.running_task  = cur_task;
            r.running_slice = slice_of[cur_task];
            expected_runs.push_back(r);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_runs.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending, expected none got task %0d",
                         $time, got.running_task);
                return;
            end
            want = expected_runs.pop_front();
            compare("running_task", want.running_task, got.running_task);
            compare("switched", want.switched, got.switched);
            compare("running_slice", want.running_slice, got.running_slice);
            compare("refilled", want.refilled, got.refilled);
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    item_t   item;
    result_t result;

    sched_tracker sched;
    int           n_ticks;
    int           n_writes;
    int           burst_left;

    counter_priority_task_scheduler #(
        .NUM_TASKS(NTASK)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sched.check_result(result);
    end

    function automatic item_t mk(logic f, int idx, int sl, int pr, bit p, bit rn);
        item_t it;
        it.func           = f;
        it.task_index     = TASK_W'(idx);
        it.slice_value    = SLICE_W'(sl);
        it.priority_value = PRIO_W'(pr);
        it.present_value  = p;
        it.runnable_value = rn;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.func = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_TICK;
        it.task_index = $urandom_range(0, 1) ? TASK_W'($urandom_range(0, 15))
                                             : TASK_W'($urandom_range(1, 4));
        case ($urandom_range(0, 3))
            0:       it.slice_value = '0;
            3:       it.slice_value = SLICE_W'($urandom_range(0, 255));
            default: it.slice_value = SLICE_W'($urandom_range(1, 6));
        endcase
        it.priority_value = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, 127))
                                                        : PRIO_W'($urandom_range(0, 8));
        it.present_value  = ($urandom_range(0, 9) != 0);
        it.runnable_value = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        sched.note_item(it);
        if (it.func == FUNC_WRITE)
            n_writes++;
        else
            n_ticks++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (sched.expected_runs.size() != 0);
    endtask

    initial
    begin
        item_t directed[$];
        sched      = new();
        n_ticks    = 0;
        n_writes   = 0;
        burst_left = 0;
        start      = 1'b0;
        item       = '0;
        rst_n      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        @(posedge clk);

        directed = '{
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_WRITE,  0, 255, 127, 1, 1),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_WRITE, 15,   3, 127, 1, 1),
            mk(FUNC_WRITE,  7,   3,   0, 1, 1),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_TICK,  15, 255, 127, 1, 1),
            mk(FUNC_WRITE, 15,   1, 127, 1, 0),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_WRITE,  1, 255,   0, 1, 1),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_WRITE,  7,   0, 127, 1, 1),
            mk(FUNC_WRITE,  1,   1,   0, 0, 0),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_WRITE,  7,   1,   5, 1, 0),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_WRITE,  2, 255, 127, 1, 1),
            mk(FUNC_WRITE,  3, 255, 127, 1, 1),
            mk(FUNC_TICK,   0,   0,   0, 0, 0),
            mk(FUNC_TICK,   0,   0,   0, 0, 0)
        };
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            send_item(random_item());
            if (k == RANDOM_ITEMS / 2)
                drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: ran %0d items (%0d ticks, %0d writes)", n_ticks + n_writes,
                 n_ticks, n_writes);
        $display("tb: saw %0d task switches and %0d slice refills", sched.n_switch,
                 sched.n_refill);
        if (sched.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
